FILE: design/pett_pkg.sv
`timescale 1ns / 1ps
// Package for the periodic event timer table: types, codes and sizes.
package pett_pkg;

  localparam int Slots      = 64;
  localparam int EventTypes = 32;
  localparam int IdxW       = (Slots > 1) ? $clog2(Slots) : 1;

  typedef enum logic [1:0] {
    ActSchedule = 2'd0,
    ActCancel   = 2'd1,
    ActTick     = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    KindSchedule = 2'd0,
    KindCancel   = 2'd1,
    KindFired    = 2'd2,
    KindTickDone = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    StIdle,
    StSched,
    StRead,
    StCheck,
    StFinish
  } state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  event_type;
    logic [31:0] payload_tag;
    logic [2:0]  priority_req;
    logic [31:0] interval;
    logic [31:0] repeat_count;
    logic [31:0] handle;
    logic [63:0] now_time;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [5:0]  event_type_res;
    logic [31:0] payload_tag_res;
    logic [2:0]  priority_res;
    logic [31:0] push_delay;
    logic [63:0] event_time;
    logic [31:0] handle_res;
    logic        success;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0] handle;
    logic [5:0]  stype;
    logic [31:0] payload;
    logic [2:0]  prio;
    logic [31:0] interval;
    logic [63:0] trigger;
    logic [31:0] remaining;
  } slot_t;

  localparam int SlotW = $bits(slot_t);

endpackage

FILE: design/pett_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, registered-read RAM.
module pett_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: design/periodic_event_timer_table.sv
`timescale 1ns / 1ps
// Periodic event timer table: slot memory, scan sequencer and result register.
// Schedule: scans the active bits, one slot per cycle, up to the last slot.
// Cancel and unpaused tick: read then check each slot in turn.
// One item at a time; the slot memory read paces cancel and tick scans, and output stalls can hold a tick.
// Reset clears active bits, time, pause and sets the next handle to one.
module periodic_event_timer_table
  import pett_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i
);

  state_e            state_q, state_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  in_t               req_q, req_d;
  out_t              pend_q, pend_d;
  logic              pend_vq, pend_vd;
  logic [Slots-1:0]  active_q, active_d;
  logic [31:0]       nh_q, nh_d;
  logic [63:0]       ct_q, ct_d;
  logic              paused_q;
  out_t              out_q, out_d;
  logic              out_vq, out_vd;

  logic              ram_we, ram_re;
  slot_t             ram_wdata, ram_rdata;
  logic              can_emit, at_end;
  out_t              fire;

  pett_ram #(.Width(SlotW), .Depth(Slots)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_vq;
  assign out_data_o  = out_q;
  assign can_emit    = !out_vq || !out_stall_i;
  assign at_end      = (idx_q == IdxW'(Slots - 1));

  always_comb begin
    fire                 = '0;
    fire.result_kind     = KindFired;
    fire.event_type_res  = ram_rdata.stype;
    fire.payload_tag_res = ram_rdata.payload;
    fire.priority_res    = ram_rdata.prio;
    fire.event_time      = req_q.now_time;
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    req_d     = req_q;
    pend_d    = pend_q;
    pend_vd   = pend_vq;
    active_d  = active_q;
    nh_d      = nh_q;
    ct_d      = ct_q;
    out_d     = out_q;
    out_vd    = out_vq && out_stall_i;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = ram_rdata;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          idx_d   = '0;
          pend_d  = '0;
          pend_vd = 1'b0;
          unique case (in_data_i.action)
            ActSchedule: begin
              if (({1'b0, in_data_i.event_type} < 7'(EventTypes)) &&
                  (in_data_i.interval != '0)) begin
                state_d = StSched;
              end else begin
                pend_d.result_kind = KindSchedule;
                pend_vd = 1'b1;
                state_d = StFinish;
              end
            end
            ActCancel: begin
              if (in_data_i.handle != '0) begin
                state_d = StRead;
              end else begin
                pend_d.result_kind = KindCancel;
                pend_vd = 1'b1;
                state_d = StFinish;
              end
            end
            ActTick: begin
              if (paused_q) begin
                pend_d.result_kind = KindTickDone;
                pend_d.event_time  = ct_q;
                pend_vd = 1'b1;
                state_d = StFinish;
              end else begin
                ct_d    = in_data_i.now_time;
                state_d = StRead;
              end
            end
            default: state_d = StIdle;
          endcase
        end
      end

      StSched: begin
        if (!active_q[idx_q]) begin
          ram_we              = 1'b1;
          ram_wdata.handle    = nh_q;
          ram_wdata.stype     = req_q.event_type;
          ram_wdata.payload   = req_q.payload_tag;
          ram_wdata.prio      = req_q.priority_req;
          ram_wdata.interval  = req_q.interval;
          ram_wdata.trigger   = ct_q + {32'd0, req_q.interval};
          ram_wdata.remaining = req_q.repeat_count;
          active_d[idx_q]     = 1'b1;
          nh_d                = nh_q + 32'd1;
          pend_d.result_kind     = KindSchedule;
          pend_d.event_type_res  = req_q.event_type;
          pend_d.payload_tag_res = req_q.payload_tag;
          pend_d.priority_res    = req_q.priority_req;
          pend_d.push_delay      = req_q.interval;
          pend_d.event_time      = ct_q;
          pend_d.handle_res      = nh_q;
          pend_d.success         = 1'b1;
          pend_vd = 1'b1;
          state_d = StFinish;
        end else if (at_end) begin
          pend_d.result_kind = KindSchedule;
          pend_vd = 1'b1;
          state_d = StFinish;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end

      StRead: begin
        ram_re  = 1'b1;
        state_d = StCheck;
      end

      StCheck: begin
        if (req_q.action == ActCancel) begin
          if (active_q[idx_q] && (ram_rdata.handle == req_q.handle)) begin
            active_d[idx_q]       = 1'b0;
            pend_d.result_kind    = KindCancel;
            pend_d.event_type_res = ram_rdata.stype;
            pend_d.success        = 1'b1;
            pend_vd = 1'b1;
            state_d = StFinish;
          end else if (at_end) begin
            pend_d.result_kind = KindCancel;
            pend_vd = 1'b1;
            state_d = StFinish;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = StRead;
          end
        end else begin
          if (active_q[idx_q] && (req_q.now_time >= ram_rdata.trigger)) begin
            if (!pend_vq || can_emit) begin
              if (pend_vq) begin
                out_d  = pend_q;
                out_vd = 1'b1;
              end
              pend_d  = fire;
              pend_vd = 1'b1;
              ram_we  = 1'b1;
              ram_wdata.trigger = ram_rdata.trigger + {32'd0, ram_rdata.interval};
              if (ram_rdata.remaining != '0) begin
                ram_wdata.remaining = ram_rdata.remaining - 32'd1;
                if (ram_rdata.remaining == 32'd1) begin
                  active_d[idx_q] = 1'b0;
                end
              end
              idx_d   = idx_q + IdxW'(1);
              state_d = at_end ? StFinish : StRead;
            end
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = at_end ? StFinish : StRead;
          end
        end
      end

      StFinish: begin
        if (can_emit) begin
          if (pend_vq) begin
            out_d      = pend_q;
            out_d.last = 1'b1;
          end else begin
            out_d             = '0;
            out_d.result_kind = KindTickDone;
            out_d.event_time  = ct_q;
            out_d.last        = 1'b1;
          end
          out_vd  = 1'b1;
          pend_vd = 1'b0;
          state_d = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      idx_q    <= '0;
      pend_vq  <= 1'b0;
      active_q <= '0;
      nh_q     <= 32'd1;
      ct_q     <= '0;
      paused_q <= 1'b0;
      out_vq   <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      pend_vq  <= pend_vd;
      active_q <= active_d;
      nh_q     <= nh_d;
      ct_q     <= ct_d;
      out_vq   <= out_vd;
      if (cfg_we_i) begin
        paused_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

endmodule

FILE: verif/periodic_event_timer_table_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the periodic event timer table: directed table, then random traffic.
module periodic_event_timer_table_tb;
  import pett_pkg::*;

  localparam logic [1:0] ActUnused = 2'd3;
  localparam int         SettleCycles = 2 * Slots + 20;
  localparam int         HoldCycles = 300;
  localparam longint     CycleLimit = 4000000;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;
  logic cfg_we_i;
  logic cfg_wdata_i;

  periodic_event_timer_table dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // timer table shadow
  logic        sh_active[Slots];
  logic [31:0] sh_handle[Slots];
  logic [5:0]  sh_type[Slots];
  logic [31:0] sh_payload[Slots];
  logic [2:0]  sh_prio[Slots];
  logic [31:0] sh_interval[Slots];
  logic [63:0] sh_trigger[Slots];
  logic [31:0] sh_remaining[Slots];
  logic [31:0] sh_next_handle;
  logic [63:0] sh_now;
  logic        sh_paused;

  out_t   pending_results[$];
  int     err_cnt;
  int     send_idle_pct;
  int     recv_stall_pct;
  bit     hold_req;
  logic   hold_on;
  longint cycle_cnt;
  row_t   directed[$];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic in_t mk_item(logic [1:0] act, logic [5:0] etype, logic [31:0] tag,
                                  logic [2:0] prio, logic [31:0] intv, logic [31:0] cnt,
                                  logic [31:0] hnd, logic [63:0] now);
    in_t it;
    it.action       = act;
    it.event_type   = etype;
    it.payload_tag  = tag;
    it.priority_req = prio;
    it.interval     = intv;
    it.repeat_count = cnt;
    it.handle       = hnd;
    it.now_time     = now;
    return it;
  endfunction

  function automatic row_t mk_row(in_t it, bit typed, kind_e kind, logic [63:0] tm);
    row_t r;
    r.item  = it;
    r.typed = typed;
    r.res   = '0;
    r.res.result_kind = kind;
    r.res.event_time  = tm;
    r.res.last        = 1'b1;
    return r;
  endfunction

  task automatic predict_timer(input in_t it, output out_t res[$]);
    out_t r;
    int   fs;
    res = {};
    r   = '0;
    fs  = -1;
    case (it.action)
      ActSchedule: begin
        if (it.event_type < EventTypes && it.interval != 0)
          for (int i = 0; i < Slots && fs < 0; i++) if (!sh_active[i]) fs = i;
        r.result_kind = KindSchedule;
        r.last        = 1'b1;
        if (fs >= 0) begin
          sh_active[fs]    = 1'b1;
          sh_handle[fs]    = sh_next_handle;
          sh_type[fs]      = it.event_type;
          sh_payload[fs]   = it.payload_tag;
          sh_prio[fs]      = it.priority_req;
          sh_interval[fs]  = it.interval;
          sh_trigger[fs]   = sh_now + {32'd0, it.interval};
          sh_remaining[fs] = it.repeat_count;
          r.event_type_res  = it.event_type;
          r.payload_tag_res = it.payload_tag;
          r.priority_res    = it.priority_req;
          r.push_delay      = it.interval;
          r.event_time      = sh_now;
          r.handle_res      = sh_next_handle;
          r.success         = 1'b1;
          sh_next_handle    = sh_next_handle + 1;
        end
        res.push_back(r);
      end
      ActCancel: begin
        if (it.handle != 0)
          for (int i = 0; i < Slots && fs < 0; i++)
            if (sh_active[i] && sh_handle[i] == it.handle) fs = i;
        r.result_kind = KindCancel;
        r.last        = 1'b1;
        if (fs >= 0) begin
          sh_active[fs]    = 1'b0;
          r.event_type_res = sh_type[fs];
          r.success        = 1'b1;
        end
        res.push_back(r);
      end
      ActTick: begin
        if (sh_paused) begin
          r.result_kind = KindTickDone;
          r.event_time  = sh_now;
          r.last        = 1'b1;
          res.push_back(r);
        end else begin
          sh_now = it.now_time;
          for (int i = 0; i < Slots; i++) begin
            if (sh_active[i] && it.now_time >= sh_trigger[i]) begin
              r = '0;
              r.result_kind     = KindFired;
              r.event_type_res  = sh_type[i];
              r.payload_tag_res = sh_payload[i];
              r.priority_res    = sh_prio[i];
              r.event_time      = it.now_time;
              res.push_back(r);
              sh_trigger[i] = sh_trigger[i] + {32'd0, sh_interval[i]};
              if (sh_remaining[i] != 0) begin
                sh_remaining[i] = sh_remaining[i] - 1;
                if (sh_remaining[i] == 0) sh_active[i] = 1'b0;
              end
            end
          end
          if (res.size() == 0) begin
            r = '0;
            r.result_kind = KindTickDone;
            r.event_time  = it.now_time;
            r.last        = 1'b1;
            res.push_back(r);
          end else begin
            res[res.size() - 1].last = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
    err_cnt++;
  endtask

  task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
    if (got !== want) report(field, got, want);
  endtask

  // drive one transaction and hold it until accepted; valid stays high afterwards unless a random idle gap follows
  task automatic send(input in_t it, input bit typed, input out_t typed_res);
    out_t res[$];
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_timer(it, res);
    if (typed && res.size() > 0) pending_results.push_back(typed_res);
    else foreach (res[i]) pending_results.push_back(res[i]);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic send_pred(input in_t it);
    send(it, 1'b0, '0);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
  endtask

  task automatic write_paused(input logic value);
    drain();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sh_paused = value;
  endtask

  function automatic in_t rand_item();
    logic [1:0]  act;
    logic [63:0] now;
    logic [31:0] intv;
    logic [31:0] cnt;
    logic [31:0] hnd;
    logic [5:0]  etype;
    int          pick;
    pick  = $urandom_range(0, 99);
    act   = (pick < 45) ? ActSchedule : (pick < 65) ? ActCancel : (pick < 99) ? ActTick
                                                                           : ActUnused;
    etype = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, EventTypes - 1));
    case ($urandom_range(0, 19))
      0:       intv = 32'd0;
      1:       intv = $urandom;
      default: intv = $urandom_range(1, 40);
    endcase
    case ($urandom_range(0, 9))
      0:          cnt = $urandom;
      1, 2, 3:    cnt = 32'd0;
      default:    cnt = $urandom_range(1, 5);
    endcase
    hnd = ($urandom_range(0, 9) == 0) ? $urandom : sh_next_handle - $urandom_range(1, 40);
    now = ($urandom_range(0, 49) == 0) ? {$urandom, $urandom}
                                       : sh_now + 64'($urandom_range(0, 30));
    return mk_item(act, etype, $urandom, 3'($urandom), intv, cnt, hnd, now);
  endfunction

  task automatic random_phase(input int count);
    in_t it;
    int  sent;
    sent = 0;
    while (sent < count) begin
      it = rand_item();
      send_pred(it);
      if (it.action != ActUnused) sent++;
    end
  endtask

  // receiver: check results and stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report("unexpected result_kind", 64'(out_data_o.result_kind), 64'd0);
        end else begin
          out_t want;
          want = pending_results.pop_front();
          check_field("result_kind", 64'(out_data_o.result_kind), 64'(want.result_kind));
          check_field("event_type_res", 64'(out_data_o.event_type_res),
                      64'(want.event_type_res));
          check_field("payload_tag_res", 64'(out_data_o.payload_tag_res),
                      64'(want.payload_tag_res));
          check_field("priority_res", 64'(out_data_o.priority_res), 64'(want.priority_res));
          check_field("push_delay", 64'(out_data_o.push_delay), 64'(want.push_delay));
          check_field("event_time", out_data_o.event_time, want.event_time);
          check_field("handle_res", 64'(out_data_o.handle_res), 64'(want.handle_res));
          check_field("success", 64'(out_data_o.success), 64'(want.success));
          check_field("last", 64'(out_data_o.last), 64'(want.last));
        end
      end
      out_stall_i <= hold_on || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // long receiver hold-off
  always begin
    wait (hold_req);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_on <= 1'b0;
    hold_req = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_stall_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = 1'b0;
    hold_req       = 1'b0;
    hold_on        = 1'b0;
    cycle_cnt      = 0;
    err_cnt        = 0;
    send_idle_pct  = 8;
    recv_stall_pct = 76;
    foreach (sh_active[i]) sh_active[i] = 1'b0;
    sh_next_handle = 32'd1;
    sh_now         = 64'd0;
    sh_paused      = 1'b0;

    directed.push_back(mk_row(mk_item(ActTick, 0, 0, 0, 0, 0, 0, 0), 1, KindTickDone, 0));
    directed.push_back(mk_row(mk_item(ActSchedule, 32, 1, 1, 5, 0, 0, 0), 1, KindSchedule, 0));
    directed.push_back(mk_row(mk_item(ActSchedule, 63, 1, 1, 5, 0, 0, 0), 1, KindSchedule, 0));
    directed.push_back(mk_row(mk_item(ActSchedule, 3, 1, 1, 0, 0, 0, 0), 1, KindSchedule, 0));
    directed.push_back(mk_row(mk_item(ActCancel, 0, 0, 0, 0, 0, 0, 0), 1, KindCancel, 0));
    directed.push_back(mk_row(mk_item(ActCancel, 0, 0, 0, 0, 0, '1, 0), 1, KindCancel, 0));
    directed.push_back(mk_row(mk_item(ActSchedule, 0, 0, 0, 1, 1, 0, 0), 0, KindSchedule, 0));
    directed.push_back(mk_row(mk_item(ActSchedule, 31, '1, 7, '1, '1, 0, 0), 0, KindSchedule,
                              0));
    directed.push_back(mk_row(mk_item(ActSchedule, 5, 32'h5a5a, 3, 10, 0, 0, 0), 0,
                              KindSchedule, 0));
    directed.push_back(mk_row(mk_item(ActTick, 0, 0, 0, 0, 0, 0, 1), 0, KindFired, 0));
    directed.push_back(mk_row(mk_item(ActTick, 0, 0, 0, 0, 0, 0, 10), 0, KindFired, 0));
    directed.push_back(mk_row(mk_item(ActCancel, 0, 0, 0, 0, 0, 2, 0), 0, KindCancel, 0));
    directed.push_back(mk_row(mk_item(ActCancel, 0, 0, 0, 0, 0, 2, 0), 1, KindCancel, 0));
    directed.push_back(mk_row(mk_item(ActTick, 0, 0, 0, 0, 0, 0, '1), 0, KindFired, 0));
    directed.push_back(mk_row(mk_item(ActTick, 0, 0, 0, 0, 0, 0, 0), 1, KindTickDone, 0));
    directed.push_back(mk_row(mk_item(ActUnused, '1, '1, '1, '1, '1, '1, '1), 0, KindTickDone,
                              0));
    directed.push_back(mk_row(mk_item(ActSchedule, 7, 32'h1234, 2, 3, 2, 0, 0), 0,
                              KindSchedule, 0));
    directed.push_back(mk_row(mk_item(ActCancel, 0, 0, 0, 0, 0, 3, 0), 0, KindCancel, 0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send(directed[i].item, directed[i].typed, directed[i].res);

    write_paused(1'b1);
    random_phase(12);
    write_paused(1'b0);

    random_phase(60);
    hold_req = 1'b1;
    send_idle_pct = 0;
    for (int i = 0; i < 8; i++) send_pred(rand_item());
    drain();
    send_idle_pct = 8;
    random_phase(80);

    send_idle_pct  = 76;
    recv_stall_pct = 8;
    random_phase(135);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_phase(135);

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
